// ===== src/c2ab_pkg.sv =====
// Package for the CIGAR to reference block converter.
// Holds the beat types, the CIGAR opcodes, the result queue sizing and the
// saturating add. No dependencies.
package c2ab_pkg;

  // Reference offsets and lengths are 31 bits wide and saturate.
  localparam int PosW    = 31;
  localparam int LenW    = 28;
  localparam int CodeW   = 4;

  // Result queue: two entries may enter in one cycle.
  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCountW = $clog2(QDepth + 1);

  // CIGAR opcodes that matter here.
  localparam logic [CodeW-1:0] OpMatch = 4'd0;
  localparam logic [CodeW-1:0] OpDel   = 4'd2;
  localparam logic [CodeW-1:0] OpSkip  = 4'd3;
  localparam logic [CodeW-1:0] OpEqual = 4'd7;
  localparam logic [CodeW-1:0] OpDiff  = 4'd8;

  typedef struct packed {
    logic [CodeW-1:0] op_code;
    logic [LenW-1:0]  op_length;
    logic             last_op;
  } cigar_op_t;

  typedef struct packed {
    logic [PosW-1:0] block_start;
    logic [PosW-1:0] block_length;
    logic            last_block;
    logic [PosW-1:0] span_length;
  } ref_block_t;

  // Adds an operation length to a 31-bit value, clamping at 2^31-1.
  function automatic logic [PosW-1:0] sat_add(input logic [PosW-1:0] a,
                                              input logic [LenW-1:0] b);
    logic [PosW:0] sum;
    sum = {1'b0, a} + {{(PosW + 1 - LenW){1'b0}}, b};
    sat_add = sum[PosW] ? {PosW{1'b1}} : sum[PosW-1:0];
  endfunction

endpackage

// ===== src/cigar_to_aligned_blocks.sv =====
// Top level of the CIGAR to reference block converter.
// Depends on c2ab_pkg for beat types, opcodes and the saturating add.
//
// Usage: the op channel carries one CIGAR operation per beat (opcode,
// length, and a flag on the last operation of the alignment). The blk
// channel returns the reference blocks covered by the read, each as a
// start offset from the alignment start and a length; the final block of
// an alignment carries last_block and the total reference span.
// Each operation updates the block tracking registers in the cycle it is
// accepted and pushes zero, one or two blocks into a four-entry result
// queue. A block appears on blk in the cycle after its operation is taken
// when the queue is empty.
// One operation is accepted every cycle as long as the queue has room for
// two more blocks. While blk is not stalled the output drains one block per
// cycle, so operations that yield at most one block run at one per cycle,
// while a stream of operations that each yield two blocks (a skip as the
// last operation) fills the queue faster than it drains and is held by op stall.
// When the receiver stalls, the head block holds and the queue fills; op
// stall rises once fewer than two queue entries are free.
// Reset empties the queue and puts the tracker inside a first block at
// offset zero; the tracker also returns to that state after each last
// operation.
module cigar_to_aligned_blocks (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   op_valid,
  output logic                   op_stall,
  input  c2ab_pkg::cigar_op_t    op,
  output logic                   blk_valid,
  input  logic                   blk_stall,
  output c2ab_pkg::ref_block_t   blk
);
  import c2ab_pkg::*;

  // Block tracking state.
  logic            inside_block, inside_block_next;
  logic [PosW-1:0] reference_offset, reference_offset_next;
  logic [PosW-1:0] current_start, current_start_next;
  logic [PosW-1:0] current_length, current_length_next;

  // Result queue.
  ref_block_t         queue [QDepth];
  logic [QPtrW-1:0]   head;
  logic [QCountW-1:0] count, count_next;
  logic [QPtrW-1:0]   tail, tail_plus;

  logic       op_take, blk_take;
  logic       consume, skip;
  logic       push_closed, push_final;
  logic [1:0] push_count;
  logic [PosW-1:0] offset_sum, length_sum;
  ref_block_t closed_block, final_block, first_entry;

  // Handshakes: stall only when fewer than two entries are free.
  assign op_stall  = count > QCountW'(QDepth - 2);
  assign op_take   = op_valid && !op_stall;
  assign blk_valid = count != '0;
  assign blk_take  = blk_valid && !blk_stall;
  assign blk       = queue[head];

  // Decode the opcode and form both saturating sums.
  assign consume = (op.op_code == OpMatch) || (op.op_code == OpDel) ||
                   (op.op_code == OpEqual) || (op.op_code == OpDiff);
  assign skip       = op.op_code == OpSkip;
  assign offset_sum = sat_add(reference_offset, op.op_length);
  assign length_sum = sat_add(current_length, op.op_length);

  // Next tracker state and the blocks that the operation produces.
  always_comb begin
    inside_block_next     = inside_block;
    reference_offset_next = reference_offset;
    current_start_next    = current_start;
    current_length_next   = current_length;
    push_closed           = 1'b0;
    if (inside_block) begin
      if (consume) begin
        current_length_next   = length_sum;
        reference_offset_next = offset_sum;
      end else if (skip) begin
        push_closed           = 1'b1;
        reference_offset_next = offset_sum;
        current_start_next    = offset_sum;
        current_length_next   = '0;
        inside_block_next     = 1'b0;
      end
    end else begin
      if (consume) begin
        current_length_next   = {{(PosW - LenW){1'b0}}, op.op_length};
        reference_offset_next = offset_sum;
        inside_block_next     = 1'b1;
      end else if (skip) begin
        reference_offset_next = offset_sum;
        current_start_next    = offset_sum;
      end
    end
    push_final = op.last_op;

    closed_block.block_start  = current_start;
    closed_block.block_length = current_length;
    closed_block.last_block   = 1'b0;
    closed_block.span_length  = '0;

    final_block.block_start  = current_start_next;
    final_block.block_length = current_length_next;
    final_block.last_block   = 1'b1;
    final_block.span_length  = reference_offset_next;

    first_entry = push_closed ? closed_block : final_block;
    push_count  = {1'b0, push_closed} + {1'b0, push_final};
  end

  // Queue pointers and occupancy.
  assign tail      = head + count[QPtrW-1:0];
  assign tail_plus = tail + QPtrW'(1);

  always_comb begin
    count_next = count;
    if (op_take) begin
      count_next = count_next + QCountW'(push_count);
    end
    if (blk_take) begin
      count_next = count_next - QCountW'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_block     <= 1'b1;
      reference_offset <= '0;
      current_start    <= '0;
      current_length   <= '0;
      head             <= '0;
      count            <= '0;
    end else begin
      count <= count_next;
      if (blk_take) begin
        head <= head + QPtrW'(1);
      end
      if (op_take) begin
        if (op.last_op) begin
          inside_block     <= 1'b1;
          reference_offset <= '0;
          current_start    <= '0;
          current_length   <= '0;
        end else begin
          inside_block     <= inside_block_next;
          reference_offset <= reference_offset_next;
          current_start    <= current_start_next;
          current_length   <= current_length_next;
        end
      end
    end
  end

  // Queue storage: up to two entries written at the tail each cycle.
  always_ff @(posedge clk) begin
    if (op_take && (push_count != 2'd0)) begin
      queue[tail] <= first_entry;
    end
    if (op_take && push_closed && push_final) begin
      queue[tail_plus] <= final_block;
    end
  end

  // The queue never holds more than its depth.
  assert property (@(posedge clk) disable iff (rst)
    count <= QCountW'(QDepth))
    else $error("result queue overflow");

  // The open block never reaches past the reference consumed so far.
  assert property (@(posedge clk) disable iff (rst)
    (current_length <= reference_offset) && (current_start <= reference_offset))
    else $error("open block lies beyond the reference offset");

  // A last operation always leaves a block waiting on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    op_take && op.last_op |=> blk_valid)
    else $error("last operation produced no final block");

  // After a last operation the tracker is back at its starting state.
  assert property (@(posedge clk) disable iff (rst)
    op_take && op.last_op |=>
      inside_block && (reference_offset == '0) && (current_length == '0))
    else $error("tracker not cleared after last operation");

endmodule
